// File: hdl/kabf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kabf_pkg
// Shared types, constants and fixed-point helpers of the angle/bias filter.
// ----------------------------------------------------------------------------
package kabf_pkg;

	localparam int unsigned W      = 48;
	localparam int unsigned CFG_W  = 47;
	localparam int unsigned FRAC   = 24;
	localparam int unsigned DT_W   = 24;
	localparam int unsigned IDX_W  = 2;
	localparam int unsigned HALF_W = 24;

	localparam logic [CFG_W-1:0] RST_Q_ANGLE = 47'd16777;
	localparam logic [CFG_W-1:0] RST_Q_BIAS  = 47'd50332;
	localparam logic [CFG_W-1:0] RST_R_MEAS  = 47'd503316;

	localparam logic [IDX_W-1:0] REG_Q_ANGLE = 2'd0;
	localparam logic [IDX_W-1:0] REG_Q_BIAS  = 2'd1;
	localparam logic [IDX_W-1:0] REG_R_MEAS  = 2'd2;

	localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	// Register file entries of the datapath.
	typedef enum logic [3:0] {
		R_ANG  = 4'd0,
		R_BIAS = 4'd1,
		R_RATE = 4'd2,
		R_PAA  = 4'd3,
		R_PAB  = 4'd4,
		R_PBA  = 4'd5,
		R_PBB  = 4'd6,
		R_T    = 4'd7,
		R_S    = 4'd8,
		R_K0   = 4'd9,
		R_K1   = 4'd10,
		R_Y    = 4'd11,
		R_MA   = 4'd12,
		R_MR   = 4'd13,
		R_DT   = 4'd14,
		R_ACC  = 4'd15
	} reg_sel_t;

	// Second-operand sources beyond the register file.
	typedef enum logic [1:0] {
		B_REG  = 2'd0,
		B_QANG = 2'd1,
		B_QBIA = 2'd2,
		B_RMEA = 2'd3
	} bsrc_t;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_NOP = 3'd4
	} op_t;

	typedef struct packed {
		logic     start;
		op_t      op;
		reg_sel_t ra;
		reg_sel_t rb;
		bsrc_t    bsrc;
		reg_sel_t rd;
		logic     load;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
	} dp_sts_t;

	function automatic logic signed [W-1:0] sat_add(input logic signed [W:0] v);
		logic signed [W-1:0] r;
		if (v > $signed({1'b0, MAXV})) r = MAXV;
		else if (v < $signed({1'b1, MINV})) r = MINV;
		else r = v[W-1:0];
		return r;
	endfunction

	function automatic logic signed [W-1:0] sign_sat(input logic [W:0] m, input logic neg,
		input logic over);
		logic signed [W-1:0] r;
		if (neg) begin
			if (over || m >= {2'b01, {(W-1){1'b0}}}) r = MINV;
			else r = W'(-$signed({1'b0, m[W-1:0]}));
		end else begin
			if (over || m > {2'b00, MAXV}) r = MAXV;
			else r = m[W-1:0];
		end
		return r;
	endfunction

endpackage : kabf_pkg
`default_nettype wire

// File: hdl/kabf_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kabf_if
// Valid/ready channels of the filter: input, result and register write.
// ----------------------------------------------------------------------------
interface kabf_in_if import kabf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic signed [W-1:0]  measured_angle;
	logic signed [W-1:0]  measured_rate;
	logic [DT_W-1:0]      time_step;
	modport source (output valid, measured_angle, measured_rate, time_step, input ready);
	modport sink (input valid, measured_angle, measured_rate, time_step, output ready);
endinterface

interface kabf_out_if import kabf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic signed [W-1:0]  angle_out;
	logic signed [W-1:0]  rate_out;
	logic signed [W-1:0]  bias_out;
	modport source (output valid, angle_out, rate_out, bias_out, input ready);
	modport sink (input valid, angle_out, rate_out, bias_out, output ready);
endinterface

interface kabf_cfg_if import kabf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [IDX_W-1:0]   index;
	logic [W-1:0]       data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/kabf_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kabf_mul
// Q24.24 multiplier: four 24x24 partial products accumulated in turn, then
// shift, truncate toward zero and saturate.
// ----------------------------------------------------------------------------
module kabf_mul import kabf_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic signed [W-1:0] a,
	input  wire logic signed [W-1:0] b,
	output logic                     done,
	output logic signed [W-1:0]      result
);
	logic [W-1:0]    x_q, y_q;
	logic            neg_q;
	logic [2*W-1:0]  acc_q;
	logic [2:0]      step_q;
	logic            busy_q;
	logic [2*HALF_W-1:0] pp;
	logic [HALF_W-1:0]   xs, ys;
	logic [2*W-1:0]  pp_sh;
	logic [W-1:0]    ma, mb;

	assign ma = a[W-1] ? W'(-a) : W'(a);
	assign mb = b[W-1] ? W'(-b) : W'(b);

	always_comb begin
		xs = step_q[0] ? x_q[W-1:HALF_W] : x_q[HALF_W-1:0];
		ys = step_q[1] ? y_q[W-1:HALF_W] : y_q[HALF_W-1:0];
		pp = xs * ys;
		pp_sh = (2*W)'(pp) << (HALF_W * (32'(step_q[0]) + 32'(step_q[1])));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == 3'd3) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				step_q <= step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= ma;
			y_q   <= mb;
			neg_q <= a[W-1] ^ b[W-1];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	logic [2*W-1:0] prod;
	assign prod = acc_q >> FRAC;
	assign result = sign_sat({1'b0, prod[W-1:0]}, neg_q, |prod[2*W-1:W]);
endmodule
`default_nettype wire

// File: hdl/kabf_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kabf_div
// Q24.24 restoring divider, one quotient bit per cycle over 72 steps.
// A zero divisor returns zero.
// ----------------------------------------------------------------------------
module kabf_div import kabf_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic signed [W-1:0] a,
	input  wire logic signed [W-1:0] b,
	output logic                     done,
	output logic signed [W-1:0]      result
);
	localparam int unsigned STEPS = W + FRAC;
	localparam int unsigned CW = $clog2(STEPS + 1);

	logic [W-1:0]    n_q, d_q;
	logic [W:0]      r_q;
	logic [W-1:0]    q_q;
	logic            over_q, neg_q, zero_q, busy_q;
	logic [CW-1:0]   cnt_q;
	logic [W:0]      r_sh;
	logic            bit_in, ge;
	logic [W:0]      q_sh;

	always_comb begin
		bit_in = n_q[W-1];
		r_sh   = {r_q[W-1:0], bit_in};
		ge     = r_sh >= {1'b0, d_q};
		q_sh   = {q_q, ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= a[W-1] ? W'(-a) : W'(a);
			d_q    <= b[W-1] ? W'(-b) : W'(b);
			neg_q  <= a[W-1] ^ b[W-1];
			zero_q <= (b == '0);
			r_q    <= '0;
			q_q    <= '0;
			over_q <= 1'b0;
		end else if (busy_q) begin
			n_q <= n_q << 1;
			r_q <= ge ? r_sh - {1'b0, d_q} : r_sh;
			// Once the quotient passes 48 bits it stays pinned at all ones.
			if (over_q || q_sh[W]) begin
				over_q <= 1'b1;
				q_q    <= '1;
			end else begin
				q_q <= q_sh[W-1:0];
			end
		end
	end

	assign result = zero_q ? '0 : sign_sat({1'b0, q_q}, neg_q, over_q);
endmodule
`default_nettype wire

// File: hdl/kabf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kabf_datapath
// Register file, saturating adder, shared multiplier and divider, and the
// configuration registers of the filter.
// ----------------------------------------------------------------------------
module kabf_datapath import kabf_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire dp_cmd_t       cmd,
	output dp_sts_t            sts,
	input  wire logic signed [W-1:0] in_angle,
	input  wire logic signed [W-1:0] in_rate,
	input  wire logic [DT_W-1:0]     in_dt,
	input  wire logic                cfg_we,
	input  wire logic [IDX_W-1:0]    cfg_idx,
	input  wire logic [W-1:0]        cfg_data,
	output logic signed [W-1:0]      angle,
	output logic signed [W-1:0]      rate,
	output logic signed [W-1:0]      bias
);
	logic signed [W-1:0] rf_q [16];
	logic [CFG_W-1:0] qa_q, qb_q, rm_q;
	logic signed [W-1:0] opa, opb, alu, mul_r, div_r;
	logic mul_done, div_done, mul_go, div_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q <= RST_Q_ANGLE;
			qb_q <= RST_Q_BIAS;
			rm_q <= RST_R_MEAS;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_Q_ANGLE: qa_q <= cfg_data[CFG_W-1:0];
				REG_Q_BIAS:  qb_q <= cfg_data[CFG_W-1:0];
				REG_R_MEAS:  rm_q <= cfg_data[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		opa = rf_q[cmd.ra];
		case (cmd.bsrc)
			B_QANG:  opb = {1'b0, qa_q};
			B_QBIA:  opb = {1'b0, qb_q};
			B_RMEA:  opb = {1'b0, rm_q};
			default: opb = rf_q[cmd.rb];
		endcase
		case (cmd.op)
			OP_SUB:  alu = sat_add({opa[W-1], opa} - {opb[W-1], opb});
			default: alu = sat_add({opa[W-1], opa} + {opb[W-1], opb});
		endcase
	end

	assign mul_go = cmd.start && cmd.op == OP_MUL;
	assign div_go = cmd.start && cmd.op == OP_DIV;

	kabf_mul u_mul (.clk, .arst_n, .start(mul_go), .a(opa), .b(opb),
		.done(mul_done), .result(mul_r));
	kabf_div u_div (.clk, .arst_n, .start(div_go), .a(opa), .b(opb),
		.done(div_done), .result(div_r));

	always_comb begin
		sts.done = mul_done || div_done ||
			(cmd.start && (cmd.op == OP_ADD || cmd.op == OP_SUB || cmd.op == OP_NOP));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) rf_q[i] <= '0;
		end else begin
			if (cmd.load) begin
				rf_q[R_MA] <= in_angle;
				rf_q[R_MR] <= in_rate;
				rf_q[R_DT] <= {{(W-DT_W){1'b0}}, in_dt};
			end else if (mul_done) begin
				rf_q[cmd.rd] <= mul_r;
			end else if (div_done) begin
				rf_q[cmd.rd] <= div_r;
			end else if (cmd.start && (cmd.op == OP_ADD || cmd.op == OP_SUB)) begin
				rf_q[cmd.rd] <= alu;
			end
		end
	end

	assign angle = rf_q[R_ANG];
	assign rate  = rf_q[R_RATE];
	assign bias  = rf_q[R_BIAS];
endmodule
`default_nettype wire

// File: hdl/kabf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kabf_ctrl
// Sequencer that steps through the filter's micro-program, one operation at
// a time, and runs the input and result handshakes.
// ----------------------------------------------------------------------------
module kabf_ctrl import kabf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output dp_cmd_t   cmd,
	input  wire dp_sts_t sts
);
	localparam int unsigned NOPS = 29;
	localparam int unsigned PW = $clog2(NOPS);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_ISS  = 4'b0010,
		S_WAIT = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	typedef struct packed {
		op_t op; reg_sel_t ra; reg_sel_t rb; bsrc_t bs; reg_sel_t rd;
	} uop_t;

	function automatic uop_t prog(input logic [PW-1:0] pc);
		uop_t u;
		case (pc)
			5'd0:  u = '{OP_SUB, R_MR,  R_BIAS, B_REG,  R_RATE};
			5'd1:  u = '{OP_MUL, R_DT,  R_RATE, B_REG,  R_ACC};
			5'd2:  u = '{OP_ADD, R_ANG, R_ACC,  B_REG,  R_ANG};
			5'd3:  u = '{OP_MUL, R_DT,  R_PBB,  B_REG,  R_T};
			5'd4:  u = '{OP_SUB, R_T,   R_PAB,  B_REG,  R_T};
			5'd5:  u = '{OP_SUB, R_T,   R_PBA,  B_REG,  R_T};
			5'd6:  u = '{OP_ADD, R_T,   R_T,    B_QANG, R_T};
			5'd7:  u = '{OP_MUL, R_DT,  R_T,    B_REG,  R_ACC};
			5'd8:  u = '{OP_ADD, R_PAA, R_ACC,  B_REG,  R_PAA};
			5'd9:  u = '{OP_MUL, R_DT,  R_PBB,  B_REG,  R_ACC};
			5'd10: u = '{OP_SUB, R_PAB, R_ACC,  B_REG,  R_PAB};
			5'd11: u = '{OP_SUB, R_PBA, R_ACC,  B_REG,  R_PBA};
			5'd12: u = '{OP_MUL, R_DT,  R_DT,   B_QBIA, R_ACC};
			5'd13: u = '{OP_ADD, R_PBB, R_ACC,  B_REG,  R_PBB};
			5'd14: u = '{OP_ADD, R_PAA, R_PAA,  B_RMEA, R_S};
			5'd15: u = '{OP_DIV, R_PAA, R_S,    B_REG,  R_K0};
			5'd16: u = '{OP_DIV, R_PBA, R_S,    B_REG,  R_K1};
			5'd17: u = '{OP_SUB, R_MA,  R_ANG,  B_REG,  R_Y};
			5'd18: u = '{OP_MUL, R_K0,  R_Y,    B_REG,  R_ACC};
			5'd19: u = '{OP_ADD, R_ANG, R_ACC,  B_REG,  R_ANG};
			5'd20: u = '{OP_MUL, R_K1,  R_Y,    B_REG,  R_ACC};
			5'd21: u = '{OP_ADD, R_BIAS, R_ACC, B_REG,  R_BIAS};
			// Covariance update: the multiplies use the old cov_aa and cov_ab,
			// so products are parked in R_T and R_S before any write back.
			5'd22: u = '{OP_MUL, R_K1,  R_PAA,  B_REG,  R_T};
			5'd23: u = '{OP_SUB, R_PBA, R_T,    B_REG,  R_PBA};
			5'd24: u = '{OP_MUL, R_K1,  R_PAB,  B_REG,  R_S};
			5'd25: u = '{OP_SUB, R_PBB, R_S,    B_REG,  R_PBB};
			5'd26: u = '{OP_MUL, R_K0,  R_PAA,  B_REG,  R_ACC};
			5'd27: u = '{OP_SUB, R_PAA, R_ACC,  B_REG,  R_PAA};
			default: u = '{OP_NOP, R_ACC, R_ACC, B_REG, R_ACC};
		endcase
		return u;
	endfunction

	state_t state_q;
	logic [PW-1:0] pc_q;
	logic [PW-1:0] pc_x;
	logic          k0pab_q;
	uop_t          u;

	// One step left: cov_ab -= k0 * old cov_ab, done after the sequence
	// since nothing after it reads cov_ab.
	always_comb begin
		pc_x = pc_q;
		u = prog(pc_x);
		if (k0pab_q) begin
			if (pc_q == 5'd28) u = '{OP_MUL, R_K0, R_PAB, B_REG, R_ACC};
			else u = '{OP_SUB, R_PAB, R_ACC, B_REG, R_PAB};
		end
		cmd.start = (state_q == S_ISS);
		cmd.op    = u.op;
		cmd.ra    = u.ra;
		cmd.rb    = u.rb;
		cmd.bsrc  = u.bs;
		cmd.rd    = u.rd;
		cmd.load  = in_valid && in_ready;
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
			k0pab_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_ISS;
					pc_q    <= '0;
					k0pab_q <= 1'b0;
				end
				S_ISS: state_q <= sts.done ? S_ISS : S_WAIT;
				S_WAIT: if (sts.done) state_q <= S_ISS;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (sts.done) begin
				if (k0pab_q && pc_q == 5'd29) begin
					state_q <= S_OUT;
				end else if (!k0pab_q && pc_q == 5'd27) begin
					k0pab_q <= 1'b1;
					pc_q    <= 5'd28;
				end else begin
					pc_q <= pc_q + 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: hdl/kalman_angle_bias_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter
// Two-state Kalman filter fusing a gyro rate and an accelerometer angle.
// ----------------------------------------------------------------------------
// The in channel takes one word per sample (angle, rate, time step); the
// out channel returns one word (filtered angle, unbiased rate, bias).
// The cfg channel writes the three noise variances and is always ready;
// write it only while the filter is idle.
// A sample runs a micro-program of 30 operations on one shared datapath:
// 17 adds and subtracts, 11 multiplies in a 24x24 multiplier used four
// times, and two divides in a one-bit-per-cycle divider. The result is
// shown once the last operation is done, and the next sample is taken the
// cycle after the result is taken. The divides take most of the time of a
// sample.
// Reset clears all estimates and covariances to zero and loads the default
// noise values. When the receiver stalls the result is held and no new
// sample is accepted.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter import kabf_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	kabf_in_if.sink    in_ch,
	kabf_out_if.source out_ch,
	kabf_cfg_if.sink   cfg
);
	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg.ready = 1'b1;

	kabf_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd, .sts
	);

	kabf_datapath u_dp (
		.clk, .arst_n, .cmd, .sts,
		.in_angle(in_ch.measured_angle), .in_rate(in_ch.measured_rate),
		.in_dt(in_ch.time_step),
		.cfg_we(cfg.valid), .cfg_idx(cfg.index), .cfg_data(cfg.data),
		.angle(out_ch.angle_out), .rate(out_ch.rate_out), .bias(out_ch.bias_out)
	);
endmodule
`default_nettype wire

// File: hdl/kabf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kabf_checker
// Port-level checks of the filter, bound to the top level.
// ----------------------------------------------------------------------------
module kabf_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic cfg_ready
);
	// Only one sample is in flight: no acceptance while a result is shown.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	// A result never follows its sample in the next cycle.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid) else $error("result too early");
	// A stalled result stays valid.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("cfg not ready");
endmodule

bind kalman_angle_bias_filter kabf_checker u_chk (
	.clk, .arst_n,
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.cfg_ready(cfg.ready)
);
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the angle/bias Kalman filter.
// A scoreboard class keeps its own copy of the filter state and noise
// registers and predicts every output word from the accepted samples.
// Directed samples cover the field extremes, zero innovation variance and
// saturation. Random phases under varied noise settings follow, with random
// gaps on both channels and a long receiver stall.
// ----------------------------------------------------------------------------
module tb;
	import kabf_pkg::*;

	typedef logic signed [W-1:0]   q_t;
	typedef logic signed [127:0]   wide_t;

	// Register index past the end of the list; writes to it are dropped.
	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		q_t angle;
		q_t rate;
		q_t bias;
	} filter_out_t;

	class filter_scoreboard;
		q_t            q_angle, q_bias, r_meas;
		q_t            ang, bias, rate, paa, pab, pba, pbb;
		filter_out_t   expected_outputs[$];
		int            mismatches;

		function new();
			q_angle    = q_t'(RST_Q_ANGLE);
			q_bias     = q_t'(RST_Q_BIAS);
			r_meas     = q_t'(RST_R_MEAS);
			ang        = '0;
			bias       = '0;
			rate       = '0;
			paa        = '0;
			pab        = '0;
			pba        = '0;
			pbb        = '0;
			mismatches = 0;
		endfunction

		function void set_noise(logic [IDX_W-1:0] idx, logic [W-1:0] data);
			q_t v;
			v = {1'b0, data[CFG_W-1:0]};
			case (idx)
				REG_Q_ANGLE: q_angle = v;
				REG_Q_BIAS:  q_bias = v;
				REG_R_MEAS:  r_meas = v;
				default: ;
			endcase
		endfunction

		function q_t clamp(wide_t v);
			wide_t hi, lo;
			hi = MAXV;
			lo = MINV;
			if (v > hi) return MAXV;
			if (v < lo) return MINV;
			return v[W-1:0];
		endfunction

		function q_t q_add(q_t a, q_t b);
			wide_t x, y;
			x = a;
			y = b;
			return clamp(x + y);
		endfunction

		function q_t q_sub(q_t a, q_t b);
			wide_t x, y;
			x = a;
			y = b;
			return clamp(x - y);
		endfunction

		// Magnitudes are shifted down, so rounding is toward zero.
		function q_t q_mul(q_t a, q_t b);
			wide_t x, y, p;
			x = a;
			y = b;
			if (x < 0) x = -x;
			if (y < 0) y = -y;
			p = (x * y) >>> FRAC;
			if ((a < 0) != (b < 0)) p = -p;
			return clamp(p);
		endfunction

		function q_t q_div(q_t a, q_t b);
			wide_t x, y, p;
			if (b == 0) return '0;
			x = a;
			y = b;
			if (x < 0) x = -x;
			if (y < 0) y = -y;
			p = (x <<< FRAC) / y;
			if ((a < 0) != (b < 0)) p = -p;
			return clamp(p);
		endfunction

		function void note_sample(q_t m_angle, q_t m_rate, logic [DT_W-1:0] step);
			q_t dt, t, s, k0, k1, y, p00, p01;
			filter_out_t e;
			dt   = {24'd0, step};
			rate = q_sub(m_rate, bias);
			ang  = q_add(ang, q_mul(dt, rate));
			t    = q_add(q_sub(q_sub(q_mul(dt, pbb), pab), pba), q_angle);
			paa  = q_add(paa, q_mul(dt, t));
			pab  = q_sub(pab, q_mul(dt, pbb));
			pba  = q_sub(pba, q_mul(dt, pbb));
			pbb  = q_add(pbb, q_mul(q_bias, dt));
			s    = q_add(paa, r_meas);
			k0   = q_div(paa, s);
			k1   = q_div(pba, s);
			y    = q_sub(m_angle, ang);
			ang  = q_add(ang, q_mul(k0, y));
			bias = q_add(bias, q_mul(k1, y));
			p00  = paa;
			p01  = pab;
			paa  = q_sub(paa, q_mul(k0, p00));
			pab  = q_sub(pab, q_mul(k0, p01));
			pba  = q_sub(pba, q_mul(k1, p00));
			pbb  = q_sub(pbb, q_mul(k1, p01));
			e.angle = ang;
			e.rate  = rate;
			e.bias  = bias;
			expected_outputs.push_back(e);
		endfunction

		function void check_output(q_t a, q_t r, q_t b);
			filter_out_t e;
			if (expected_outputs.size() == 0) begin
				$error("output word with nothing expected: angle %0d rate %0d bias %0d",
					a, r, b);
				mismatches++;
				return;
			end
			e = expected_outputs.pop_front();
			if (a !== e.angle) begin
				$error("angle_out: expected %0d, actual %0d", e.angle, a);
				mismatches++;
			end
			if (r !== e.rate) begin
				$error("rate_out: expected %0d, actual %0d", e.rate, r);
				mismatches++;
			end
			if (b !== e.bias) begin
				$error("bias_out: expected %0d, actual %0d", e.bias, b);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	kabf_in_if  in_ch();
	kabf_out_if out_ch();
	kabf_cfg_if cfg();

	kalman_angle_bias_filter i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source),
		.cfg    (cfg.sink)
	);

	filter_scoreboard sb = new();

	int  rx_hold_left = 0;
	bit  gaps_on = 1'b1;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		#40ms;
		$display("kalman_angle_bias_filter test failed");
		$finish;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (!gaps_on || roll < 55) return 0;
		if (roll < 93) return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	initial begin
		int g;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_left > 0) begin
				out_ch.ready <= 1'b0;
				rx_hold_left--;
			end else begin
				g = pick_gap();
				if (g > 0) begin
					out_ch.ready <= 1'b0;
					rx_hold_left = g - 1;
				end else begin
					out_ch.ready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_output(out_ch.angle_out, out_ch.rate_out, out_ch.bias_out);
	end

	task automatic send_sample(q_t m_angle, q_t m_rate, logic [DT_W-1:0] step);
		int g;
		g = pick_gap();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid          <= 1'b1;
		in_ch.measured_angle <= m_angle;
		in_ch.measured_rate  <= m_rate;
		in_ch.time_step      <= step;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_sample(m_angle, m_rate, step);
	endtask

	// Lowers valid and waits until every expected word has come back.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.expected_outputs.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_noise(logic [IDX_W-1:0] idx, logic [W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		sb.set_noise(idx, data);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic q_t any_word();
		return q_t'({$urandom, $urandom});
	endfunction

	// Sensor-like value within about two units either side of zero.
	function automatic q_t near_zero();
		return q_t'($signed({1'b0, 31'($urandom_range(0, 32'h0400_0000))})) - q_t'(32'h0200_0000);
	endfunction

	function automatic q_t pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 75) return near_zero();
		if (roll < 95) return any_word();
		return (roll < 97) ? MAXV : MINV;
	endfunction

	function automatic logic [DT_W-1:0] pick_step();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) return DT_W'($urandom_range(1, 32'h0004_0000));
		if (roll < 80) return '0;
		if (roll < 95) return DT_W'($urandom);
		return '1;
	endfunction

	function automatic logic [W-1:0] pick_noise();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 6) return W'($urandom_range(0, 32'h0100_0000));
		if (roll < 8) return W'({$urandom, $urandom});
		return (roll == 8) ? '0 : '1;
	endfunction

	initial begin
		arst_n               = 1'b0;
		in_ch.valid          = 1'b0;
		in_ch.measured_angle = '0;
		in_ch.measured_rate  = '0;
		in_ch.time_step      = '0;
		cfg.valid            = 1'b0;
		cfg.index            = '0;
		cfg.data             = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Default noise: field extremes and a zero time step.
		send_sample('0, '0, '0);
		send_sample(MAXV, MAXV, '1);
		send_sample(MINV, MINV, '1);
		send_sample(MAXV, MINV, DT_W'(1));
		send_sample(MINV, MAXV, '0);
		send_sample(q_t'(48'sd16777216), q_t'(-48'sd8388608), DT_W'(167772));
		send_sample(q_t'(-48'sd1), q_t'(48'sd1), DT_W'(167772));
		drain();

		// Zero noise with a zero time step keeps the innovation variance at zero.
		write_noise(REG_Q_ANGLE, '0);
		write_noise(REG_Q_BIAS, '0);
		write_noise(REG_R_MEAS, '0);
		write_noise(REG_UNUSED, '1);
		send_sample(q_t'(48'sd33554432), q_t'(48'sd100), '0);
		send_sample(MAXV, MINV, '0);
		send_sample(MINV, MAXV, '0);
		send_sample(q_t'(48'sd5), q_t'(-48'sd5), DT_W'(1));
		drain();

		// Largest noise values drive the covariance into saturation.
		write_noise(REG_Q_ANGLE, '1);
		write_noise(REG_Q_BIAS, '1);
		write_noise(REG_R_MEAS, '1);
		send_sample(MAXV, MAXV, '1);
		send_sample(MINV, MINV, '1);
		send_sample(MAXV, MINV, '1);
		send_sample('0, MAXV, DT_W'(8388608));
		send_sample(MINV, '0, '1);
		send_sample(q_t'(48'sd1), q_t'(-48'sd1), DT_W'(1));
		drain();

		// The receiver holds off while samples keep coming; no input gaps.
		gaps_on = 1'b0;
		rx_hold_left = 1500;
		repeat (10) send_sample(pick_value(), pick_value(), pick_step());
		drain();
		gaps_on = 1'b1;

		for (int phase = 0; phase < 8; phase++) begin
			if (phase == 0) begin
				write_noise(REG_Q_ANGLE, W'(RST_Q_ANGLE));
				write_noise(REG_Q_BIAS, W'(RST_Q_BIAS));
				write_noise(REG_R_MEAS, W'(RST_R_MEAS));
			end else begin
				write_noise(REG_Q_ANGLE, pick_noise());
				write_noise(REG_Q_BIAS, pick_noise());
				write_noise(REG_R_MEAS, pick_noise());
				if (phase[0]) write_noise(REG_UNUSED, W'({$urandom, $urandom}));
			end
			gaps_on = (phase != 3);
			repeat (200) send_sample(pick_value(), pick_value(), pick_step());
			drain();
		end
		gaps_on = 1'b1;

		repeat (300) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_outputs.size() == 0)
			$display("kalman_angle_bias_filter test passed");
		else
			$display("kalman_angle_bias_filter test failed");
		$finish;
	end

endmodule

// File: files.f
hdl/kabf_pkg.sv
hdl/kabf_if.sv
hdl/kabf_mul.sv
hdl/kabf_div.sv
hdl/kabf_datapath.sv
hdl/kabf_ctrl.sv
hdl/kalman_angle_bias_filter.sv
hdl/kabf_checker.sv
dv/tb.sv
